[rtl/core/irc_tok_pkg.sv]
`default_nettype none

package irc_tok_pkg;

    // Argument limit: the argument that brings the count to this value
    // takes the rest of the line.
    localparam int MAX_PARAMS = 15;

    // Wide enough to hold MAX_PARAMS itself.
    localparam int ARG_CNT_W = $clog2(MAX_PARAMS + 1);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [1:0] role_t;

    localparam role_t ROLE_DROP = 2'd0;
    localparam role_t ROLE_NICK = 2'd1;
    localparam role_t ROLE_HOST = 2'd2;
    localparam role_t ROLE_ARG  = 2'd3;

    // Reported counts saturate at this value.
    localparam logic [3:0] REPORT_MAX = 4'd15;

endpackage

`default_nettype wire

[rtl/core/irc_line_tokenizer_unit.sv]
`default_nettype none

// Byte tokenizer for one protocol line: every accepted beat carries one byte
// and yields exactly one labeled result beat. A leading colon opens the sender
// prefix (nick, then user@host after the first '!'), spaces split arguments,
// and a colon-led argument or the argument that reaches the parameter limit
// takes the rest of the line. Delimiters come out with role "dropped". The
// block sustains one byte per clock while the output is drained: short
// parser logic sits between the input handshake and the output register, so
// a byte's result appears in the cycle after acceptance, and s_ready stays
// high whenever the output register is empty or drained in the same cycle.
// A beat with s_line_end set returns the parser to line start for the next byte.
module irc_line_tokenizer_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_line_end,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_role,
    output logic [3:0]      m_arg_number,
    output logic            m_arg_begin,
    output logic [3:0]      m_args_found,
    output logic            m_line_done
);

    localparam int CNT_W = irc_tok_pkg::ARG_CNT_W;
    // Compare domain wide enough for both the counter and the report limit.
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    // Parser modes
    localparam logic [2:0] MODE_START      = 3'd0;
    localparam logic [2:0] MODE_PREFIX     = 3'd1;
    localparam logic [2:0] MODE_GAP        = 3'd2;
    localparam logic [2:0] MODE_WORD       = 3'd3;
    localparam logic [2:0] MODE_TRAIL_OPEN = 3'd4;
    localparam logic [2:0] MODE_REST       = 3'd5;

    // Parser state
    logic [2:0]       mode_reg;
    logic [2:0]       mode_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             split_reg;
    logic             split_next;

    // Result register
    logic             m_valid_reg;
    logic [7:0]       byte_reg;
    irc_tok_pkg::role_t role_reg;
    irc_tok_pkg::role_t role_next;
    logic [3:0]       argnum_reg;
    logic [3:0]       argnum_next;
    logic             begin_reg;
    logic             begin_next;
    logic [3:0]       found_reg;
    logic [3:0]       found_next;
    logic             done_reg;

    logic             accept;
    logic             is_gap;
    logic [CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0] cnt_wide;
    logic [CMP_W-1:0] cnt_less_wide;

    // Take a new beat whenever the result slot is free or draining now.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // A line without a prefix starts directly in the argument gap.
    assign is_gap = (mode_reg == MODE_GAP) ||
                    ((mode_reg == MODE_START) && (s_data_byte != irc_tok_pkg::CH_COLON));

    assign cnt_inc = cnt_reg + CNT_W'(1);

    // Advance the parser by one byte.
    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        split_next = split_reg;
        role_next  = irc_tok_pkg::ROLE_DROP;
        begin_next = 1'b0;

        if (is_gap) begin
            if (s_data_byte == irc_tok_pkg::CH_SPACE) begin
                mode_next = MODE_GAP;
            end else if (s_data_byte == irc_tok_pkg::CH_COLON) begin
                // Trailing argument counts at once, even if empty.
                cnt_next  = cnt_inc;
                mode_next = MODE_TRAIL_OPEN;
            end else begin
                cnt_next   = cnt_inc;
                role_next  = irc_tok_pkg::ROLE_ARG;
                begin_next = 1'b1;
                mode_next  = (cnt_inc >= CNT_W'(irc_tok_pkg::MAX_PARAMS)) ?
                             MODE_REST : MODE_WORD;
            end
        end else begin
            case (mode_reg)
                MODE_START: begin
                    // Leading colon: drop it and open the sender prefix.
                    mode_next = MODE_PREFIX;
                end
                MODE_PREFIX: begin
                    if (s_data_byte == irc_tok_pkg::CH_SPACE) begin
                        mode_next = MODE_GAP;
                    end else if (s_data_byte == irc_tok_pkg::CH_BANG && !split_reg) begin
                        split_next = 1'b1;
                    end else begin
                        role_next = split_reg ? irc_tok_pkg::ROLE_HOST
                                              : irc_tok_pkg::ROLE_NICK;
                    end
                end
                MODE_WORD: begin
                    if (s_data_byte == irc_tok_pkg::CH_SPACE) begin
                        mode_next = MODE_GAP;
                    end else begin
                        role_next = irc_tok_pkg::ROLE_ARG;
                    end
                end
                MODE_TRAIL_OPEN: begin
                    // Any byte after the opening colon begins the trailing text.
                    role_next  = irc_tok_pkg::ROLE_ARG;
                    begin_next = 1'b1;
                    mode_next  = MODE_REST;
                end
                MODE_REST: begin
                    role_next = irc_tok_pkg::ROLE_ARG;
                end
                default: begin
                    mode_next = MODE_START;
                end
            endcase
        end
    end

    // Report counts, saturated to the 4-bit result fields.
    always_comb begin
        cnt_wide      = CMP_W'(cnt_next);
        cnt_less_wide = cnt_wide - CMP_W'(1);

        if (cnt_wide > CMP_W'(irc_tok_pkg::REPORT_MAX)) begin
            found_next = irc_tok_pkg::REPORT_MAX;
        end else begin
            found_next = cnt_wide[3:0];
        end

        if (cnt_wide == '0) begin
            argnum_next = 4'd0;
        end else if (cnt_less_wide > CMP_W'(irc_tok_pkg::REPORT_MAX)) begin
            argnum_next = irc_tok_pkg::REPORT_MAX;
        end else begin
            argnum_next = cnt_less_wide[3:0];
        end
    end

    // Parser state: update on every accepted beat, clear at line end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_START;
            cnt_reg   <= '0;
            split_reg <= 1'b0;
        end else if (accept) begin
            if (s_line_end) begin
                mode_reg  <= MODE_START;
                cnt_reg   <= '0;
                split_reg <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                split_reg <= split_next;
            end
        end
    end

    // Output valid: set on accept, drop once the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload: load only on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg   <= s_data_byte;
            role_reg   <= role_next;
            argnum_reg <= argnum_next;
            begin_reg  <= begin_next;
            found_reg  <= found_next;
            done_reg   <= s_line_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_role       = role_reg;
    assign m_arg_number = argnum_reg;
    assign m_arg_begin  = begin_reg;
    assign m_args_found = found_reg;
    assign m_line_done  = done_reg;

    // An argument start is always an argument byte of a counted argument.
    a_begin_is_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && begin_reg |-> (role_reg == irc_tok_pkg::ROLE_ARG) && (found_reg != 4'd0))
        else $error("arg_begin on a byte that is not a counted argument byte");

    // Current argument index never runs ahead of the count.
    a_argnum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (argnum_reg <= found_reg) &&
                        ((found_reg != 4'd0) || (argnum_reg == 4'd0)))
        else $error("arg_number inconsistent with args_found");

    // Line end returns the parser to line start.
    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_line_end |=> (mode_reg == MODE_START) && (cnt_reg == '0) && !split_reg)
        else $error("parser state not cleared after line end");

    // Counter stops at the parameter limit.
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(irc_tok_pkg::MAX_PARAMS))
        else $error("argument counter beyond parameter limit");

    // Counter holds without an accepted beat; it moves only on one, by one step or a clear at line end.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(cnt_reg))
        else $error("argument counter moved without an accepted beat");

endmodule

`default_nettype wire
